// ===== sv/servo_pulse_generator_defines.svh =====
// ----------------------------------------------------------------------------
// servo_pulse_generator_defines
// Assertion macros shared by the divider and sequencer modules.
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_GENERATOR_DEFINES_SVH
`define SERVO_PULSE_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Types and constants shared by the servo pulse generator modules.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int KIND_W     = 3;
  localparam int US_W       = 16;
  localparam int TRIM_W     = 13;
  localparam int UPT_W      = 12;
  localparam int UPD_W      = 10;
  localparam int DEG_W      = 8;
  localparam int REM_W      = 20;
  localparam int DIV_W      = 24;
  localparam int DVS_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DEG_W-1:0] RANGE_DEG = 8'd180;

  // floor(x / RANGE_DEG) as (x * MAP_RECIP) >> MAP_SHIFT, exact for x < 2**DIV_W
  localparam int                   MAP_RCP_W = 25;
  localparam logic [MAP_RCP_W-1:0] MAP_RECIP = 25'd23860930;
  localparam int                   MAP_SHIFT = 32;

  localparam logic [US_W-1:0]   MIN_WIDTH_RST  = 16'd600;
  localparam logic [US_W-1:0]   MAX_WIDTH_RST  = 16'd2400;
  localparam logic [US_W-1:0]   FRAME_RST      = 16'd20000;
  localparam logic [TRIM_W-1:0] TRIM_RST       = 13'd0;
  localparam logic [UPT_W-1:0]  US_PER_TICK_RST = 12'd10;
  localparam logic [UPD_W-1:0]  US_PER_DEG_RST = 10'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_DEG    = 3'd1,
    KIND_US     = 3'd2,
    KIND_ATTACH = 3'd3,
    KIND_DETACH = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WIDTH   = 3'd0,
    CFG_MAX_WIDTH   = 3'd1,
    CFG_FRAME       = 3'd2,
    CFG_TRIM        = 3'd3,
    CFG_US_PER_TICK = 3'd4,
    CFG_US_PER_DEG  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_REM = 2'd0,
    DIV_HI  = 2'd1,
    DIV_LO  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     do_tick;
    logic     do_attach;
    logic     do_detach;
    logic     w_from_value;
    logic     est_from_target;
    logic     est_from_quot;
    logic     travel;
    logic     map_capture;
    logic     trim;
    logic     hi_capture;
    logic     lo_capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } spg_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  enabled;
    logic  target_known;
    logic  moving;
    logic  div_done;
  } spg_status_t;

endpackage

// ===== sv/spg_divider.sv =====
// ----------------------------------------------------------------------------
// spg_divider
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
`include "servo_pulse_generator_defines.svh"

module spg_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [spg_pkg::DIV_W-1:0] dividend,
  input  logic [spg_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [spg_pkg::DIV_W-1:0] quotient
);
  import spg_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    shifted;
  logic              ge;
  logic [DVS_W:0]    diff;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `SPG_ASSERT_IMP(a_no_restart, start, !busy_r, "divider started while busy")

endmodule

// ===== sv/spg_datapath.sv =====
// ----------------------------------------------------------------------------
// spg_datapath
// Registers, pulse counter, travel timer, width mapping and result word.
// ----------------------------------------------------------------------------
module spg_datapath #(
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [spg_pkg::KIND_W-1:0]     in_kind,
  input  logic [spg_pkg::US_W-1:0]       in_value,
  input  spg_pkg::spg_cmd_t              cmd,
  output spg_pkg::spg_status_t           status,
  output logic                           out_pulse_level,
  output logic                           out_is_attached,
  output logic                           out_moving,
  output logic [spg_pkg::DEG_W-1:0]      out_position_deg,
  output logic                           out_position_valid
);
  import spg_pkg::*;

  localparam int CB    = COUNT_BITS;
  localparam int W_W   = US_W + 3;
  localparam int SAT_W = (CB > DIV_W) ? CB : DIV_W;
  localparam int MP_W  = DIV_W + MAP_RCP_W;

  // configuration
  logic [US_W-1:0]          min_w_r, max_w_r, frame_r;
  logic signed [TRIM_W-1:0] trim_r;
  logic [UPT_W-1:0]         upt_r;
  logic [UPD_W-1:0]         upd_r;

  // pulse and travel state
  logic             level_r, level_nxt;
  logic             enabled_r, enabled_nxt;
  logic [CB-1:0]    cnt_r, cnt_nxt;
  logic [CB-1:0]    hi_r, hi_nxt;
  logic [CB-1:0]    lo_r, lo_nxt;
  logic [DEG_W-1:0] target_r, target_nxt;
  logic             known_r, known_nxt;
  logic             dir_down_r, dir_down_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  // working registers
  logic [KIND_W-1:0]     kind_r;
  logic [US_W-1:0]       value_r;
  logic [DEG_W-1:0]      est_r;
  logic signed [W_W-1:0] w_r;
  logic [DIV_W-1:0]      prod_mag_r;
  logic                  prod_neg_r;

  logic [UPT_W-1:0]         upt_nz;
  logic [UPD_W-1:0]         upd_nz;
  logic [DEG_W-1:0]         pos;
  logic [DEG_W-1:0]         diff_deg;
  logic                     dir_calc;
  logic [UPD_W+DEG_W-1:0]   travel_mul;
  logic signed [US_W:0]     span;
  logic [US_W:0]            span_abs;
  logic [DIV_W-1:0]         prod_mag;
  logic [MP_W-1:0]          map_prod;
  logic signed [W_W-1:0]    map_q;
  logic signed [W_W-1:0]    map_w;
  logic signed [W_W-1:0]    w_trim;
  logic signed [W_W-1:0]    w_lo_clamp;
  logic signed [W_W-1:0]    w_clamp;
  logic [REM_W-1:0]         rem_step;
  logic [REM_W-1:0]         q_rem;
  logic [DEG_W-1:0]         room_up;
  logic [DEG_W-1:0]         est_q;
  logic [US_W-1:0]          w_u;
  logic [DIV_W-1:0]         div_dividend;
  logic [DVS_W-1:0]         div_divisor;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quot;

  function automatic logic [CB-1:0] sat_cnt(input logic [DIV_W-1:0] q);
    logic [SAT_W-1:0] qx;
    logic [SAT_W-1:0] mx;
    qx = SAT_W'(q);
    mx = SAT_W'({CB{1'b1}});
    return (qx > mx) ? {CB{1'b1}} : CB'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_w_r <= MIN_WIDTH_RST;
      max_w_r <= MAX_WIDTH_RST;
      frame_r <= FRAME_RST;
      trim_r  <= TRIM_RST;
      upt_r   <= US_PER_TICK_RST;
      upd_r   <= US_PER_DEG_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_WIDTH:   min_w_r <= cfg_data[US_W-1:0];
        CFG_MAX_WIDTH:   max_w_r <= cfg_data[US_W-1:0];
        CFG_FRAME:       frame_r <= cfg_data[US_W-1:0];
        CFG_TRIM:        trim_r  <= cfg_data[TRIM_W-1:0];
        CFG_US_PER_TICK: upt_r   <= cfg_data[UPT_W-1:0];
        CFG_US_PER_DEG:  upd_r   <= cfg_data[UPD_W-1:0];
        default: ;
      endcase
    end
  end

  assign upt_nz = (upt_r == '0) ? UPT_W'(1) : upt_r;
  assign upd_nz = (upd_r == '0) ? UPD_W'(1) : upd_r;

  assign pos = (value_r > US_W'(RANGE_DEG)) ? RANGE_DEG : value_r[DEG_W-1:0];

  // travel from current estimate to new target
  assign dir_calc   = !(pos > est_r);
  assign diff_deg   = dir_calc ? (est_r - pos) : (pos - est_r);
  assign travel_mul = (UPD_W+DEG_W)'(upd_nz) * (UPD_W+DEG_W)'(diff_deg);

  // linear map, magnitude form so the quotient truncates toward zero
  assign span     = signed'({1'b0, max_w_r}) - signed'({1'b0, min_w_r});
  assign span_abs = span[US_W] ? (~span + 1'b1) : span;
  assign prod_mag = DIV_W'(pos) * DIV_W'(span_abs[US_W-1:0]);

  // divide by the range through a reciprocal multiply
  assign map_prod = MP_W'(prod_mag_r) * MP_W'(MAP_RECIP);
  assign map_q    = signed'(W_W'(map_prod[MAP_SHIFT +: US_W]));
  assign map_w    = (prod_neg_r ? -map_q : map_q) + signed'(W_W'(min_w_r));

  assign w_trim     = w_r + W_W'(trim_r);
  assign w_lo_clamp = (w_trim < signed'(W_W'(min_w_r))) ? signed'(W_W'(min_w_r)) : w_trim;
  assign w_clamp    = (w_lo_clamp > signed'(W_W'(max_w_r))) ? signed'(W_W'(max_w_r))
                                                             : w_lo_clamp;
  assign w_u        = w_r[US_W-1:0];

  // position estimate from the remaining travel quotient
  assign q_rem   = div_quot[REM_W-1:0];
  assign room_up = RANGE_DEG - target_r;
  always_comb begin
    if (dir_down_r) begin
      est_q = (q_rem >= REM_W'(room_up)) ? RANGE_DEG : (target_r + q_rem[DEG_W-1:0]);
    end else begin
      est_q = (q_rem >= REM_W'(target_r)) ? '0 : (target_r - q_rem[DEG_W-1:0]);
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_REM: begin
        div_dividend = DIV_W'(rem_r);
        div_divisor  = DVS_W'(upd_nz);
      end
      DIV_HI: begin
        div_dividend = DIV_W'(w_u);
        div_divisor  = upt_nz;
      end
      default: begin
        div_dividend = (frame_r >= w_u) ? DIV_W'(frame_r - w_u) : '0;
        div_divisor  = upt_nz;
      end
    endcase
  end

  spg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign rem_step = REM_W'(upt_nz);

  always_comb begin
    level_nxt    = level_r;
    enabled_nxt  = enabled_r;
    cnt_nxt      = cnt_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    target_nxt   = target_r;
    known_nxt    = known_r;
    dir_down_nxt = dir_down_r;
    rem_nxt      = rem_r;
    if (cmd.do_tick) begin
      if (enabled_r) begin
        if (!level_r && cnt_r >= lo_r) begin
          level_nxt = 1'b1;
          cnt_nxt   = '0;
        end else if (level_r && cnt_r >= hi_r) begin
          level_nxt = 1'b0;
          cnt_nxt   = '0;
        end else if (cnt_r != {CB{1'b1}}) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rem_nxt = (rem_r > rem_step) ? (rem_r - rem_step) : '0;
    end
    if (cmd.do_attach) begin
      enabled_nxt = 1'b1;
      level_nxt   = 1'b0;
    end
    if (cmd.do_detach) begin
      enabled_nxt = 1'b0;
    end
    if (cmd.travel) begin
      if (known_r) begin
        dir_down_nxt = dir_calc;
        rem_nxt      = REM_W'(travel_mul);
      end
      target_nxt = pos;
      known_nxt  = 1'b1;
    end
    if (cmd.hi_capture) begin
      hi_nxt = sat_cnt(div_quot);
    end
    if (cmd.lo_capture) begin
      lo_nxt = sat_cnt(div_quot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= 1'b0;
      enabled_r  <= 1'b0;
      cnt_r      <= '0;
      hi_r       <= '0;
      lo_r       <= '0;
      target_r   <= '0;
      known_r    <= 1'b0;
      dir_down_r <= 1'b0;
      rem_r      <= '0;
    end else begin
      level_r    <= level_nxt;
      enabled_r  <= enabled_nxt;
      cnt_r      <= cnt_nxt;
      hi_r       <= hi_nxt;
      lo_r       <= lo_nxt;
      target_r   <= target_nxt;
      known_r    <= known_nxt;
      dir_down_r <= dir_down_nxt;
      rem_r      <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (cmd.est_from_target) begin
      est_r <= target_r;
    end else if (cmd.est_from_quot) begin
      est_r <= est_q;
    end
    if (cmd.travel) begin
      prod_mag_r <= prod_mag;
      prod_neg_r <= span[US_W];
    end
    if (cmd.w_from_value) begin
      w_r <= signed'(W_W'(value_r));
    end else if (cmd.map_capture) begin
      w_r <= map_w;
    end else if (cmd.trim) begin
      w_r <= w_clamp;
    end
    if (cmd.out_load) begin
      out_pulse_level    <= level_r;
      out_is_attached    <= enabled_r;
      out_moving         <= rem_r != '0;
      out_position_deg   <= known_r ? est_r : '0;
      out_position_valid <= known_r;
    end
  end

  assign status.kind         = kind_t'(kind_r);
  assign status.enabled      = enabled_r;
  assign status.target_known = known_r;
  assign status.moving       = rem_r != '0;
  assign status.div_done     = div_done;

endmodule

// ===== sv/spg_ctrl.sv =====
// ----------------------------------------------------------------------------
// spg_ctrl
// Sequencer: decodes each word, steps the datapath and divider, hands off.
// ----------------------------------------------------------------------------
`include "servo_pulse_generator_defines.svh"

module spg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  spg_pkg::spg_status_t status,
  output spg_pkg::spg_cmd_t    cmd
);
  import spg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CUR_WAIT,
    S_TRAVEL,
    S_MAP,
    S_TRIM,
    S_HI_GO,
    S_HI_WAIT,
    S_LO_GO,
    S_LO_WAIT,
    S_POS,
    S_POS_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   div_wait;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    cmd.div_sel   = DIV_REM;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.kind)
          KIND_TICK: begin
            cmd.do_tick = 1'b1;
            state_nxt   = S_POS;
          end
          KIND_DEG: begin
            if (status.target_known && status.moving) begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = DIV_REM;
              state_nxt     = S_CUR_WAIT;
            end else begin
              cmd.est_from_target = 1'b1;
              state_nxt           = S_TRAVEL;
            end
          end
          KIND_US: begin
            cmd.w_from_value = 1'b1;
            state_nxt        = status.enabled ? S_TRIM : S_POS;
          end
          KIND_ATTACH: begin
            cmd.do_attach = 1'b1;
            state_nxt     = S_POS;
          end
          KIND_DETACH: begin
            cmd.do_detach = 1'b1;
            state_nxt     = S_POS;
          end
          default: state_nxt = S_POS;
        endcase
      end
      S_CUR_WAIT: begin
        if (status.div_done) begin
          cmd.est_from_quot = 1'b1;
          state_nxt         = S_TRAVEL;
        end
      end
      S_TRAVEL: begin
        cmd.travel = 1'b1;
        state_nxt  = status.enabled ? S_MAP : S_POS;
      end
      S_MAP: begin
        cmd.map_capture = 1'b1;
        state_nxt       = S_TRIM;
      end
      S_TRIM: begin
        cmd.trim  = 1'b1;
        state_nxt = S_HI_GO;
      end
      S_HI_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_HI;
        state_nxt     = S_HI_WAIT;
      end
      S_HI_WAIT: begin
        if (status.div_done) begin
          cmd.hi_capture = 1'b1;
          state_nxt      = S_LO_GO;
        end
      end
      S_LO_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LO;
        state_nxt     = S_LO_WAIT;
      end
      S_LO_WAIT: begin
        if (status.div_done) begin
          cmd.lo_capture = 1'b1;
          state_nxt      = S_POS;
        end
      end
      S_POS: begin
        if (status.moving) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_REM;
          state_nxt     = S_POS_WAIT;
        end else begin
          cmd.est_from_target = 1'b1;
          state_nxt           = S_DONE;
        end
      end
      S_POS_WAIT: begin
        if (status.div_done) begin
          cmd.est_from_quot = 1'b1;
          state_nxt         = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  assign div_wait = state_r == S_CUR_WAIT || state_r == S_HI_WAIT ||
                    state_r == S_LO_WAIT || state_r == S_POS_WAIT;

  `SPG_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy after accept")
  `SPG_ASSERT_IMP(a_done_in_wait, status.div_done, div_wait, "divider result outside a wait state")
  `SPG_ASSERT_NXT(a_result_posted, state_r == S_DONE && !out_valid_r, out_valid_r && state_r == S_IDLE, "result not posted")

endmodule

// ===== sv/servo_pulse_generator.sv =====
// Divisions run one at a time on the shared 24-step restoring divider.
// Throughput: one word at a time; a tick while traveling needs one division, a
//   microsecond write up to three, a degree write up to four.
// Reset: synchronous active-low; settings and servo state take their defaults,
//   detached and low, no position known; out_valid clears, the output fields do not.
// ----------------------------------------------------------------------------
// servo_pulse_generator
// Servo pulse generator top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
module servo_pulse_generator #(
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spg_pkg::KIND_W-1:0]     in_kind,
  input  logic [spg_pkg::US_W-1:0]       in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_pulse_level,
  output logic                           out_is_attached,
  output logic                           out_moving,
  output logic [spg_pkg::DEG_W-1:0]      out_position_deg,
  output logic                           out_position_valid
);
  import spg_pkg::*;

  spg_cmd_t    cmd;
  spg_status_t status;

  spg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  spg_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_kind            (in_kind),
    .in_value           (in_value),
    .cmd                (cmd),
    .status             (status),
    .out_pulse_level    (out_pulse_level),
    .out_is_attached    (out_is_attached),
    .out_moving         (out_moving),
    .out_position_deg   (out_position_deg),
    .out_position_valid (out_position_valid)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the servo pulse generator word by word against a behavioral
// predictor: directed corner words first, then fixed edge settings and random
// settings with random traffic, random sender gaps, receiver stalls and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import spg_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
  localparam longint DEG_SPAN      = 180;
  localparam longint COUNT_CEIL    = 65535;
  localparam longint TRAVEL_MASK   = 20'hFFFFF;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     REPORT_LIMIT  = 10;

  typedef struct packed {
    logic             level;
    logic             attached;
    logic             moving;
    logic [DEG_W-1:0] position;
    logic             known;
  } servo_status_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind;
  logic [US_W-1:0]       in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_pulse_level;
  logic                  out_is_attached;
  logic                  out_moving;
  logic [DEG_W-1:0]      out_position_deg;
  logic                  out_position_valid;

  servo_pulse_generator #(.COUNT_BITS(16)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pulse_level   (out_pulse_level),
    .out_is_attached   (out_is_attached),
    .out_moving        (out_moving),
    .out_position_deg  (out_position_deg),
    .out_position_valid(out_position_valid)
  );

  // settings mirror
  longint set_min_us, set_max_us, set_frame_us, set_trim_us, set_us_per_tick, set_us_per_deg;
  // servo state mirror
  bit     sv_level, sv_attached, sv_known, sv_down;
  longint sv_count, sv_high_ticks, sv_low_ticks, sv_target, sv_travel_us;

  servo_status_t expected_status[$];
  int failures    = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b0;
  int stall_pct   = 0;
  int stall_run   = 0;
  int hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint nonzero(input longint v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint clamp_count(input longint v);
    if (v < 0) return 0;
    if (v > COUNT_CEIL) return COUNT_CEIL;
    return v;
  endfunction

  function automatic void reset_model();
    set_min_us      = longint'(MIN_WIDTH_RST);
    set_max_us      = longint'(MAX_WIDTH_RST);
    set_frame_us    = longint'(FRAME_RST);
    set_trim_us     = longint'($signed(TRIM_RST));
    set_us_per_tick = longint'(US_PER_TICK_RST);
    set_us_per_deg  = longint'(US_PER_DEG_RST);
    sv_level = 1'b0; sv_attached = 1'b0; sv_known = 1'b0; sv_down = 1'b0;
    sv_count = 0; sv_high_ticks = 0; sv_low_ticks = 0; sv_target = 0; sv_travel_us = 0;
  endfunction

  function automatic longint estimate_deg();
    longint p;
    longint q;
    p = sv_target;
    if (sv_travel_us != 0) begin
      q = sv_travel_us / nonzero(set_us_per_deg);
      p = sv_down ? p + q : p - q;
    end
    if (p < 0) p = 0;
    if (p > DEG_SPAN) p = DEG_SPAN;
    return p;
  endfunction

  function automatic void command_width(input longint width);
    longint per;
    if (!sv_attached) return;
    width = width + set_trim_us;
    if (width < set_min_us) width = set_min_us;
    if (width > set_max_us) width = set_max_us;
    per = nonzero(set_us_per_tick);
    sv_high_ticks = clamp_count(width / per);
    sv_low_ticks  = clamp_count((set_frame_us - width) / per);
  endfunction

  function automatic void command_degrees(input logic [US_W-1:0] value);
    longint pos, cur, diff, span, width;
    pos = (value > DEG_SPAN) ? DEG_SPAN : longint'(value);
    if (sv_known) begin
      cur = (sv_travel_us != 0) ? estimate_deg() : sv_target;
      diff = (pos > cur) ? pos - cur : cur - pos;
      sv_down = !(pos > cur);
      sv_travel_us = (nonzero(set_us_per_deg) * diff) & TRAVEL_MASK;
    end
    span = set_max_us - set_min_us;
    width = (pos * span) / DEG_SPAN + set_min_us;
    command_width(width);
    sv_target = pos;
    sv_known = 1'b1;
  endfunction

  function automatic void tick_servo();
    longint d;
    if (sv_attached) begin
      if (!sv_level && sv_count >= sv_low_ticks) begin
        sv_level = 1'b1;
        sv_count = 0;
      end else if (sv_level && sv_count >= sv_high_ticks) begin
        sv_level = 1'b0;
        sv_count = 0;
      end else if (sv_count < COUNT_CEIL) begin
        sv_count++;
      end
    end
    d = nonzero(set_us_per_tick);
    sv_travel_us = (sv_travel_us > d) ? sv_travel_us - d : 0;
  endfunction

  function automatic servo_status_t advance_servo(input logic [KIND_W-1:0] kind,
                                                  input logic [US_W-1:0] value);
    servo_status_t status;
    case (kind)
      KIND_TICK:   tick_servo();
      KIND_DEG:    command_degrees(value);
      KIND_US:     command_width(longint'(value));
      KIND_ATTACH: begin
        sv_attached = 1'b1;
        sv_level = 1'b0;
      end
      KIND_DETACH: sv_attached = 1'b0;
      default: ;
    endcase
    status.level    = sv_level;
    status.attached = sv_attached;
    status.moving   = (sv_travel_us != 0);
    status.position = sv_known ? DEG_W'(estimate_deg()) : '0;
    status.known    = sv_known;
    return status;
  endfunction

  // receiver: own stall pattern plus a counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check, sampled mid-cycle so the coming edge is known to take the word
  always @(negedge clk) begin : check_word
    servo_status_t got;
    servo_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_pulse_level, out_is_attached, out_moving, out_position_deg, out_position_valid};
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected word: level=%0d attached=%0d moving=%0d pos=%0d known=%0d",
                   got.level, got.attached, got.moving, got.position, got.known);
      end else begin
        want = expected_status.pop_front();
        if (got.level !== want.level || got.attached !== want.attached ||
            got.moving !== want.moving || got.position !== want.position ||
            got.known !== want.known) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("mismatch: expected level=%0d attached=%0d moving=%0d pos=%0d known=%0d, %s",
                     want.level, want.attached, want.moving, want.position, want.known,
                     $sformatf("actual level=%0d attached=%0d moving=%0d pos=%0d known=%0d",
                               got.level, got.attached, got.moving, got.position, got.known));
        end
      end
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [US_W-1:0] value);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    expected_status.push_back(advance_servo(kind, value));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input logic [US_W-1:0] min_us, input logic [US_W-1:0] max_us,
                                input logic [US_W-1:0] frame_us, input logic [TRIM_W-1:0] trim,
                                input logic [UPT_W-1:0] per_tick, input logic [UPD_W-1:0] per_deg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_WIDTH;
    cfg_data  <= min_us;
    @(posedge clk);
    cfg_index <= CFG_MAX_WIDTH;
    cfg_data  <= max_us;
    @(posedge clk);
    cfg_index <= CFG_FRAME;
    cfg_data  <= frame_us;
    @(posedge clk);
    cfg_index <= CFG_TRIM;
    cfg_data  <= CFG_DATA_W'(trim);
    @(posedge clk);
    cfg_index <= CFG_US_PER_TICK;
    cfg_data  <= CFG_DATA_W'(per_tick);
    @(posedge clk);
    cfg_index <= CFG_US_PER_DEG;
    cfg_data  <= CFG_DATA_W'(per_deg);
    @(posedge clk);
    cfg_we <= 1'b0;
    set_min_us      = longint'(min_us);
    set_max_us      = longint'(max_us);
    set_frame_us    = longint'(frame_us);
    set_trim_us     = longint'($signed(trim));
    set_us_per_tick = longint'(per_tick);
    set_us_per_deg  = longint'(per_deg);
  endtask

  task automatic send_random_words(input int count);
    int pick;
    logic [KIND_W-1:0] kind;
    logic [US_W-1:0] value;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      value = US_W'($urandom_range(0, 16'hFFFF));
      if (pick < 68) begin
        kind = KIND_TICK;
      end else if (pick < 80) begin
        kind = KIND_DEG;
        if ($urandom_range(0, 4) != 0) value = US_W'($urandom_range(0, 200));
      end else if (pick < 88) begin
        kind = KIND_US;
        if ($urandom_range(0, 1) != 0) value = US_W'($urandom_range(0, 3000));
      end else if (pick < 93) begin
        kind = KIND_ATTACH;
      end else if (pick < 97) begin
        kind = KIND_DETACH;
      end else begin
        kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      end
      send_word(kind, value);
    end
  endtask

  task automatic run_mix(input int count, input bit gaps, input int stall);
    gaps_on = gaps;
    stall_pct = stall;
    send_word(KIND_ATTACH, US_W'($urandom_range(0, 16'hFFFF)));
    send_random_words(count);
    drain();
  endtask

  task automatic test_directed_cases();
    gaps_on = 1'b0;
    stall_pct = 0;
    send_word(KIND_TICK, 16'hFFFF);
    send_word(KIND_US, 16'd1500);
    send_word(KIND_DEG, 16'd90);
    send_word(KIND_ATTACH, 16'd0);
    send_word(KIND_DEG, 16'd0);
    send_word(KIND_TICK, 16'd0);
    send_word(KIND_DETACH, 16'hFFFF);
    send_word(KIND_TICK, 16'd0);
    send_word(KIND_TICK, 16'd0);
    send_word(KIND_DEG, 16'd120);
    send_word(KIND_ATTACH, 16'hFFFF);
    send_word(KIND_DEG, 16'd180);
    send_word(KIND_DEG, 16'd181);
    send_word(KIND_DEG, 16'hFFFF);
    send_word(KIND_US, 16'd0);
    send_word(KIND_US, 16'hFFFF);
    send_word(KIND_SPARE_FIRST, 16'hFFFF);
    send_word(KIND_SPARE_MID, 16'h0000);
    send_word(KIND_SPARE_LAST, 16'hA5A5);
    send_word(KIND_DEG, 16'd45);
    send_word(KIND_TICK, 16'h5A5A);
    send_word(KIND_TICK, 16'd0);
    send_word(KIND_ATTACH, 16'd0);
    send_word(KIND_TICK, 16'd0);
    drain();
  endtask

  task automatic test_zero_divisors();
    write_settings(16'd5, 16'd25, 16'd60, 13'd0, 12'd0, 10'd0);
    run_mix(60, 1'b1, 20);
  endtask

  task automatic test_inverted_limits();
    write_settings(16'd2000, 16'd1000, 16'd3000, 13'h1000, 12'd100, 10'd1);
    run_mix(60, 1'b0, 0);
  endtask

  task automatic test_full_scale();
    write_settings(16'd0, 16'hFFFF, 16'hFFFF, 13'h0FFF, 12'hFFF, 10'h3FF);
    run_mix(60, 1'b1, 50);
  endtask

  task automatic test_width_beyond_frame();
    write_settings(16'd0, 16'hFFFF, 16'd1, 13'h0FFF, 12'hFFF, 10'd7);
    run_mix(60, 1'b0, 30);
  endtask

  task automatic test_minimum_settings();
    write_settings(16'd0, 16'd0, 16'd1, 13'd0, 12'd1, 10'd1);
    run_mix(60, 1'b1, 0);
  endtask

  task automatic test_random_settings();
    int min_us, max_us, frame_us, per_tick, per_deg;
    logic [TRIM_W-1:0] trim;
    for (int phase = 0; phase < 10; phase++) begin
      min_us = $urandom_range(0, 2500);
      max_us = $urandom_range(0, 3000);
      frame_us = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16'hFFFF)
                                             : $urandom_range(1000, 30000);
      trim = ($urandom_range(0, 1) == 0) ? TRIM_W'($urandom_range(0, 400) - 200)
                                         : TRIM_W'($urandom_range(0, 8191));
      per_tick = frame_us / $urandom_range(8, 60);
      if ($urandom_range(0, 4) == 0) per_tick = $urandom_range(1, 4095);
      if (per_tick < 1) per_tick = 1;
      if (per_tick > 4095) per_tick = 4095;
      per_deg = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 1023);
      write_settings(US_W'(min_us), US_W'(max_us), US_W'(frame_us), trim,
                     UPT_W'(per_tick), UPD_W'(per_deg));
      run_mix(155, phase[0], (phase % 3) * 30);
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    stall_pct = 0;
    send_word(KIND_ATTACH, 16'd0);
    hold_cycles = 300;
    send_random_words(40);
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MIN_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_kind   = KIND_TICK;
    in_value  = '0;
    out_stall = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_zero_divisors();
    test_inverted_limits();
    test_full_scale();
    test_width_beyond_frame();
    test_minimum_settings();
    test_random_settings();
    test_backpressure();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_status.size() != 0) failures++;
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== servo_pulse_generator.f =====
+incdir+sv
sv/spg_pkg.sv
sv/spg_divider.sv
sv/spg_datapath.sv
sv/spg_ctrl.sv
sv/servo_pulse_generator.sv
bench/testbench.sv
